### design/tse_pkg.sv
// Shared types and constants for the topological sort engine.
package tse_pkg;
   localparam int unsigned NODE_W = 7;
   localparam int unsigned STATUS_W = 2;
   localparam logic [STATUS_W-1:0] STATUS_ORDER = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_CYCLE = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_OVERFLOW = 2'd2;
   localparam logic OP_ADD_EDGE = 1'b0;
   localparam logic OP_SORT = 1'b1;

   typedef enum logic [9:0] {
      ST_IDLE   = 10'b0000000001,
      ST_SCAN   = 10'b0000000010,
      ST_POP    = 10'b0000000100,
      ST_HEAD   = 10'b0000001000,
      ST_EDGE   = 10'b0000010000,
      ST_DEG    = 10'b0000100000,
      ST_EMIT   = 10'b0001000000,
      ST_EMITW  = 10'b0010000000,
      ST_FAIL   = 10'b0100000000,
      ST_CLEAR  = 10'b1000000000
   } state_type;
endpackage

### design/tse_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
module tse_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

### design/topological_sort_engine.sv
// Topological sort engine: top level with sequencer and graph memories.
//
// Kahn topological sort over nodes 1..node_count. An add-edge transaction is
// accepted every cycle while idle; a pending register finishes its list-head
// and in-degree read-modify-write. A sort transaction scans the in-degree
// memory (one node per cycle), walks each queued node's edge list (ST_POP,
// ST_HEAD, ST_EDGE; per edge ST_DEG and ST_EMIT do the in-degree update),
// emits one result per cycle from the order queue while the output is not
// stalled (or one cycle/overflow status if not all nodes were ordered), then
// clears all MAX_NODES list heads and in-degrees. No transaction is accepted during a sort.
module topological_sort_engine #(
   parameter int unsigned MAX_NODES = 64,
   parameter int unsigned MAX_EDGES = 256
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_write_enable,
   input  logic [tse_pkg::NODE_W-1:0]    csr_write_data,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_operation,
   input  logic [tse_pkg::NODE_W-1:0]    req_src_node,
   input  logic [tse_pkg::NODE_W-1:0]    req_dst_node,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [tse_pkg::NODE_W-1:0]    rsp_node_out,
   output logic [tse_pkg::STATUS_W-1:0]  rsp_status,
   output logic                          rsp_last
);
   localparam int unsigned NA = $clog2(MAX_NODES);
   localparam int unsigned EA = $clog2(MAX_EDGES);
   localparam int unsigned EW = EA + 1;            // edge index plus null
   localparam int unsigned CW = $clog2(MAX_NODES + 1);
   localparam int unsigned DW = $clog2(MAX_EDGES + 1);
   localparam int unsigned NW = tse_pkg::NODE_W;
   localparam logic [EW-1:0] EDGE_NULL = EW'(MAX_EDGES);

   tse_pkg::state_type state_ff, state_in;
   logic [NW-1:0] ncount_ff, ncount_in;
   logic [DW-1:0] etotal_ff, etotal_in;
   logic          ovf_ff, ovf_in;
   logic [CW-1:0] rptr_ff, rptr_in, wptr_ff, wptr_in, idx_ff, idx_in;
   logic [EW-1:0] edge_ff, edge_in;
   logic [EA:0]   guard_ff, guard_in;
   logic [NW-1:0] tgt_ff, tgt_in;
   logic          rv_ff, rv_in;
   logic [NW-1:0] rnode_ff, rnode_in;
   logic [tse_pkg::STATUS_W-1:0] rstat_ff, rstat_in;
   logic          rlast_ff, rlast_in;

   // effective node count
   logic [CW-1:0] n_eff;
   always_comb begin
      if (ncount_ff == '0) n_eff = CW'(1);
      else if ({1'b0, ncount_ff} > (NW+1)'(MAX_NODES)) n_eff = CW'(MAX_NODES);
      else n_eff = CW'(ncount_ff);
   end

   // memories
   logic          hd_we;  logic [NA-1:0] hd_wa, hd_ra; logic [EW-1:0] hd_wd, hd_rd;
   logic          dg_we;  logic [NA-1:0] dg_wa, dg_ra; logic [DW-1:0] dg_wd, dg_rd;
   logic          et_we;  logic [EA-1:0] et_wa, et_ra;
   logic [NW+EW-1:0] et_wd, et_rd;
   logic          q_we;   logic [NA-1:0] q_wa, q_ra;   logic [NW-1:0] q_wd, q_rd;

   tse_ram #(.WIDTH(EW), .DEPTH(MAX_NODES)) u_head (.clock, .wr_en(hd_we),
      .wr_addr(hd_wa), .wr_data(hd_wd), .rd_addr(hd_ra), .rd_data(hd_rd));
   tse_ram #(.WIDTH(DW), .DEPTH(MAX_NODES)) u_deg (.clock, .wr_en(dg_we),
      .wr_addr(dg_wa), .wr_data(dg_wd), .rd_addr(dg_ra), .rd_data(dg_rd));
   tse_ram #(.WIDTH(NW+EW), .DEPTH(MAX_EDGES)) u_edge (.clock, .wr_en(et_we),
      .wr_addr(et_wa), .wr_data(et_wd), .rd_addr(et_ra), .rd_data(et_rd));
   tse_ram #(.WIDTH(NW), .DEPTH(MAX_NODES)) u_queue (.clock, .wr_en(q_we),
      .wr_addr(q_wa), .wr_data(q_wd), .rd_addr(q_ra), .rd_data(q_rd));

   // add-edge path: list head and degree pending read-modify-write
   logic          pend_ff, pend_in;
   logic [NA-1:0] psrc_ff, psrc_in, pdst_ff, pdst_in;
   logic [EA-1:0] pedge_ff, pedge_in;
   // last written values for forwarding between back-to-back edges
   logic          fwd_h_ok, fwd_d_ok;
   logic [EW-1:0] head_val;
   logic [DW-1:0] deg_val;
   logic [NA-1:0] lsrc_ff, lsrc_in, ldst_ff, ldst_in;
   logic [EW-1:0] lhead_ff, lhead_in;
   logic [DW-1:0] ldeg_ff, ldeg_in;
   logic          lval_ff, lval_in;

   assign fwd_h_ok = lval_ff && (lsrc_ff == psrc_ff);
   assign fwd_d_ok = lval_ff && (ldst_ff == pdst_ff);
   assign head_val = fwd_h_ok ? lhead_ff : hd_rd;
   assign deg_val  = fwd_d_ok ? ldeg_ff  : dg_rd;

   logic req_acc, edge_ok, out_free;
   logic [CW-1:0] src_w, dst_w;
   assign src_w = CW'(req_src_node);
   assign dst_w = CW'(req_dst_node);
   assign req_stall = (state_ff != tse_pkg::ST_IDLE)
                      || (pend_ff && req_operation == tse_pkg::OP_SORT);
   assign req_acc = req_valid && !req_stall;
   assign edge_ok = (req_src_node != '0) && (req_dst_node != '0)
                    && (src_w <= n_eff) && (dst_w <= n_eff)
                    && (req_src_node <= NW'(MAX_NODES))
                    && (req_dst_node <= NW'(MAX_NODES));
   assign out_free = !rv_ff || !rsp_stall;

   logic [NA-1:0] tgt_a;
   logic          tgt_ok;
   assign tgt_a  = NA'(tgt_ff - NW'(1));
   assign tgt_ok = (tgt_ff != '0) && ({1'b0, tgt_ff} <= (NW+1)'(n_eff));

   always_comb begin
      state_in = state_ff;
      ncount_in = csr_write_enable ? csr_write_data : ncount_ff;
      etotal_in = etotal_ff; ovf_in = ovf_ff;
      rptr_in = rptr_ff; wptr_in = wptr_ff; idx_in = idx_ff;
      edge_in = edge_ff; guard_in = guard_ff; tgt_in = tgt_ff;
      rv_in = rv_ff && rsp_stall;
      rnode_in = rnode_ff; rstat_in = rstat_ff; rlast_in = rlast_ff;
      pend_in = 1'b0; psrc_in = psrc_ff; pdst_in = pdst_ff; pedge_in = pedge_ff;
      lval_in = lval_ff; lsrc_in = lsrc_ff; ldst_in = ldst_ff;
      lhead_in = lhead_ff; ldeg_in = ldeg_ff;
      hd_we = 1'b0; hd_wa = '0; hd_wd = '0; hd_ra = '0;
      dg_we = 1'b0; dg_wa = '0; dg_wd = '0; dg_ra = '0;
      et_we = 1'b0; et_wa = '0; et_wd = '0; et_ra = '0;
      q_we = 1'b0;  q_wa = '0;  q_wd = '0;  q_ra = '0;

      // finish a pending edge: write back head, degree and edge table entry
      if (pend_ff) begin
         hd_we = 1'b1; hd_wa = psrc_ff; hd_wd = EW'(pedge_ff);
         dg_we = 1'b1; dg_wa = pdst_ff; dg_wd = deg_val + DW'(1);
         et_we = 1'b1; et_wa = pedge_ff;
         et_wd = {NW'({1'b0, pdst_ff} + (NA+1)'(1)), head_val};
         lval_in = 1'b1; lsrc_in = psrc_ff; ldst_in = pdst_ff;
         lhead_in = EW'(pedge_ff); ldeg_in = deg_val + DW'(1);
      end

      unique case (state_ff)
         tse_pkg::ST_IDLE: begin
            if (req_acc && req_operation == tse_pkg::OP_ADD_EDGE && edge_ok) begin
               if (etotal_ff >= DW'(MAX_EDGES)) begin
                  ovf_in = 1'b1;
               end else begin
                  pend_in = 1'b1;
                  psrc_in = NA'(req_src_node - NW'(1));
                  pdst_in = NA'(req_dst_node - NW'(1));
                  pedge_in = EA'(etotal_ff);
                  etotal_in = etotal_ff + DW'(1);
                  hd_ra = NA'(req_src_node - NW'(1));
                  dg_ra = NA'(req_dst_node - NW'(1));
               end
            end else if (req_acc && req_operation == tse_pkg::OP_SORT) begin
               state_in = tse_pkg::ST_SCAN;
               idx_in = '0; rptr_in = '0; wptr_in = '0;
               lval_in = 1'b0;
               dg_ra = '0;
            end
         end
         tse_pkg::ST_SCAN: begin
            // dg_rd holds in_degree[idx]
            if (dg_rd == '0) begin
               q_we = 1'b1; q_wa = NA'(wptr_ff); q_wd = NW'(idx_ff + CW'(1));
               wptr_in = wptr_ff + CW'(1);
            end
            idx_in = idx_ff + CW'(1);
            dg_ra = NA'(idx_ff + CW'(1));
            if (idx_ff + CW'(1) == n_eff) state_in = tse_pkg::ST_POP;
         end
         tse_pkg::ST_POP: begin
            if (rptr_ff == wptr_ff) begin
               idx_in = '0;
               if (wptr_ff == n_eff) begin
                  state_in = tse_pkg::ST_EMITW; q_ra = '0;
               end else begin
                  state_in = tse_pkg::ST_FAIL;
               end
            end else begin
               q_ra = NA'(rptr_ff);
               rptr_in = rptr_ff + CW'(1);
               state_in = tse_pkg::ST_HEAD;
            end
         end
         tse_pkg::ST_HEAD: begin
            // q_rd is the popped node (always in 1..n)
            hd_ra = NA'(q_rd - NW'(1));
            guard_in = '0;
            state_in = tse_pkg::ST_EDGE;
            edge_in = EDGE_NULL; // unused: ST_EDGE reads the list head from hd_rd directly
            tgt_in = '0;
         end
         tse_pkg::ST_EDGE: begin
            // tgt_ff and guard_ff both zero means take list head just read
            logic [EW-1:0] e;
            e = (tgt_ff == '0 && guard_ff == '0) ? hd_rd : edge_ff;
            if (e >= EDGE_NULL || guard_ff >= (EA+1)'(MAX_EDGES)) begin
               state_in = tse_pkg::ST_POP;
            end else begin
               et_ra = EA'(e);
               state_in = tse_pkg::ST_DEG;
               tgt_in = NW'(1); // marks list walk in progress
            end
         end
         tse_pkg::ST_DEG: begin
            // et_rd is {target, link}; read degree of target
            tgt_in = et_rd[NW+EW-1:EW];
            edge_in = et_rd[EW-1:0];
            guard_in = guard_ff + (EA+1)'(1);
            dg_ra = NA'(et_rd[NW+EW-1:EW] - NW'(1));
            state_in = tse_pkg::ST_EMIT;  // reuse as degree update step
         end
         tse_pkg::ST_EMIT: begin
            // degree update: dg_rd is in_degree[tgt]
            if (tgt_ok && dg_rd != '0) begin
               dg_we = 1'b1; dg_wa = tgt_a; dg_wd = dg_rd - DW'(1);
               if (dg_rd == DW'(1) && wptr_ff < CW'(MAX_NODES)) begin
                  q_we = 1'b1; q_wa = NA'(wptr_ff); q_wd = tgt_ff;
                  wptr_in = wptr_ff + CW'(1);
               end
            end
            state_in = tse_pkg::ST_EDGE;
            tgt_in = NW'(1);
         end
         tse_pkg::ST_EMITW: begin
            if (out_free) begin
               // advance: fetch queue[idx] for the next step
               q_ra = NA'(idx_ff);
               if (idx_ff != '0) begin
                  rv_in = 1'b1; rnode_in = q_rd;
                  rstat_in = tse_pkg::STATUS_ORDER;
                  rlast_in = (idx_ff == n_eff);
               end
               if (idx_ff == n_eff) begin
                  state_in = tse_pkg::ST_CLEAR; idx_in = '0;
               end else begin
                  idx_in = idx_ff + CW'(1);
               end
            end else begin
               // hold: keep queue[idx-1] on the read port
               q_ra = NA'(idx_ff - CW'(1));
            end
         end
         tse_pkg::ST_FAIL: begin
            if (out_free) begin
               rv_in = 1'b1; rnode_in = '0; rlast_in = 1'b1;
               rstat_in = ovf_ff ? tse_pkg::STATUS_OVERFLOW : tse_pkg::STATUS_CYCLE;
               state_in = tse_pkg::ST_CLEAR; idx_in = '0;
            end
         end
         tse_pkg::ST_CLEAR: begin
            hd_we = 1'b1; hd_wa = NA'(idx_ff); hd_wd = EDGE_NULL;
            dg_we = 1'b1; dg_wa = NA'(idx_ff); dg_wd = '0;
            idx_in = idx_ff + CW'(1);
            if (idx_ff == CW'(MAX_NODES - 1)) begin
               state_in = tse_pkg::ST_IDLE;
               etotal_in = '0; ovf_in = 1'b0; lval_in = 1'b0;
            end
         end
         default: state_in = tse_pkg::ST_IDLE;
      endcase
   end

   // ST_EMITW: idx 0 primes the queue read; entries emitted at idx 1..n
   // map idx k to queue[k-1] because the read issued at idx k-1 returns now.

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tse_pkg::ST_CLEAR;
         ncount_ff <= NW'(1);
         etotal_ff <= '0; ovf_ff <= 1'b0;
         rv_ff <= 1'b0; pend_ff <= 1'b0; lval_ff <= 1'b0;
         idx_ff <= '0;
      end else begin
         state_ff <= state_in;
         ncount_ff <= ncount_in;
         etotal_ff <= etotal_in; ovf_ff <= ovf_in;
         rv_ff <= rv_in; pend_ff <= pend_in; lval_ff <= lval_in;
         idx_ff <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      rptr_ff <= rptr_in; wptr_ff <= wptr_in;
      edge_ff <= edge_in; guard_ff <= guard_in; tgt_ff <= tgt_in;
      rnode_ff <= rnode_in; rstat_ff <= rstat_in; rlast_ff <= rlast_in;
      psrc_ff <= psrc_in; pdst_ff <= pdst_in; pedge_ff <= pedge_in;
      lsrc_ff <= lsrc_in; ldst_ff <= ldst_in; lhead_ff <= lhead_in; ldeg_ff <= ldeg_in;
   end

   assign rsp_valid = rv_ff;
   assign rsp_node_out = rnode_ff;
   assign rsp_status = rstat_ff;
   assign rsp_last = rlast_ff;
endmodule
